FILE: hw/rtl/csig_pkg.sv
// shared types, constants and signature tables for the code signature scanner
`default_nettype none

package csig_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned MAX_WORDS  = 1048576;
  localparam int unsigned CNT_W      = $clog2(MAX_WORDS + 1);
  localparam int unsigned WIN_DEPTH  = 9;
  localparam int unsigned SIG_COUNT  = 4;
  localparam int unsigned SIG_MAXLEN = WIN_DEPTH + 1;

  typedef logic [WORD_W-1:0]     word_t;
  typedef word_t [WIN_DEPTH-1:0] window_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [SIG_COUNT-1:0]  sig_vec_t;

  // signature order: string compare, character search, byte fill, word fill
  localparam int unsigned SIG_LEN [SIG_COUNT] = '{8, 8, 7, 10};

  localparam word_t SIG_WORDS [SIG_COUNT][SIG_MAXLEN] = '{
    '{32'hEA000001, 32'hE2800001, 32'hE2811001, 32'hE5D03000, 32'hE3530000,
      32'h0A000002, 32'hE5D12000, 32'hE1530002, 32'h00000000, 32'h00000000},
    '{32'hE5D02000, 32'hEA000002, 32'hE1520001, 32'h012FFF1E, 32'hE5F02001,
      32'hE3520000, 32'h1AFFFFFA, 32'hE3A00000, 32'h00000000, 32'h00000000},
    '{32'hEA000001, 32'hE1403091, 32'hE2800001, 32'hE3520000, 32'hE2422001,
      32'h1AFFFFFA, 32'hE12FFF1E, 32'h00000000, 32'h00000000, 32'h00000000},
    '{32'hE92D03F0, 32'hE0819002, 32'hE1A0C2A2, 32'hE081C28C, 32'hE1A02000,
      32'hE1A03002, 32'hE1A04002, 32'hE1A05002, 32'hE1A06002, 32'hE1A07002}
  };

  // window state handed from the window module to the matcher
  typedef struct packed {
    window_t window;
    count_t  count;
    logic    saturated;
  } win_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/csig_window.sv
// sliding window of the last nine words and the saturating word counter
`default_nettype none

module csig_window
  import csig_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       shift_en,
  input  wire logic       clear,
  input  wire word_t      word_in,
  output      win_state_t state_o
);

  window_t window_r, window_nxt;
  count_t  count_r, count_nxt;

  always_comb begin
    window_nxt = window_r;
    count_nxt  = count_r;
    if (shift_en) begin
      for (int i = WIN_DEPTH - 1; i > 0; i--) begin
        window_nxt[i] = window_r[i-1];
      end
      window_nxt[0] = word_in;
      count_nxt     = count_r + count_t'(1);
    end
    // end of image returns the scan to its reset state
    if (clear) begin
      window_nxt = '0;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      count_r  <= '0;
    end else begin
      window_r <= window_nxt;
      count_r  <= count_nxt;
    end
  end

  assign state_o.window    = window_r;
  assign state_o.count     = count_r;
  assign state_o.saturated = (count_r >= count_t'(MAX_WORDS));

endmodule

`default_nettype wire

FILE: hw/rtl/csig_matcher.sv
// parallel constant compares of the incoming word plus window against the signatures
`default_nettype none

module csig_matcher
  import csig_pkg::*;
(
  input  wire word_t      word_in,
  input  wire win_state_t state_i,
  input  wire sig_vec_t   found_i,
  output      sig_vec_t   hit_o
);

  word_t recent [SIG_MAXLEN];

  always_comb begin
    recent[0] = word_in;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      recent[i+1] = state_i.window[i];
    end
  end

  always_comb begin
    logic hit;
    int   idx;
    for (int s = 0; s < SIG_COUNT; s++) begin
      hit = 1'b1;
      for (int k = 0; k < SIG_MAXLEN; k++) begin
        if (k < SIG_LEN[s]) begin
          // signature word k sits len-1-k items back
          idx = SIG_LEN[s] - 1 - k;
          if (recent[idx[3:0]] != SIG_WORDS[s][k]) begin
            hit = 1'b0;
          end
        end
      end
      hit_o[s] = hit && !found_i[s]
                 && (state_i.count >= count_t'(SIG_LEN[s] - 1));
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/code_signature_scanner.sv
// the result is registered and appears on out_* in the cycle after the item with in_tlast is accepted
// throughput: one item per cycle; input stalls only while a finished result is not taken
// compare depth is set by the ten-word signature against a nine-word window plus new item
// reset (synchronous, active low) clears window, counter, match records, load address
// and the result valid flag; the scan state also clears after every last item
`default_nettype none

module code_signature_scanner
  import csig_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  // configuration: load_address
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_wdata,
  // input channel
  input  wire logic          in_tvalid,
  output      logic          in_tready,
  input  wire logic [31:0]   in_tdata,   // code_word
  input  wire logic          in_tlast,   // last_word
  // result channel
  output      logic          out_tvalid,
  input  wire logic          out_tready,
  output      logic [127:0]  out_tdata   // strcmp_address, strchr_address,
                                         // byte_fill_address, word_fill_address
);

  word_t      load_addr_r;
  sig_vec_t   found_r, found_nxt;
  word_t      match_addr_r [SIG_COUNT];
  word_t      match_addr_nxt [SIG_COUNT];
  logic       out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r;

  win_state_t win_state;
  sig_vec_t   hit;
  logic       accept, step, finish;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign step      = accept && !win_state.saturated;
  assign finish    = accept && in_tlast;

  csig_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (step),
    .clear    (finish),
    .word_in  (in_tdata),
    .state_o  (win_state)
  );

  csig_matcher u_matcher (
    .word_in  (in_tdata),
    .state_i  (win_state),
    .found_i  (found_r),
    .hit_o    (hit)
  );

  always_comb begin
    count_t start;
    found_nxt = found_r;
    for (int s = 0; s < SIG_COUNT; s++) begin
      match_addr_nxt[s] = match_addr_r[s];
      start = win_state.count - count_t'(SIG_LEN[s] - 1);
      if (step && hit[s]) begin
        found_nxt[s] = 1'b1;
        // a match at the image start is recorded with a zero address, which reads as not found
        if (start == '0) begin
          match_addr_nxt[s] = '0;
        end else begin
          match_addr_nxt[s] = load_addr_r + (word_t'(start) << 2);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_addr_r <= '0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < SIG_COUNT; s++) begin
        match_addr_r[s] <= '0;
      end
    end else begin
      if (cfg_we) begin
        load_addr_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
      if (finish) begin
        found_r <= '0;
        for (int s = 0; s < SIG_COUNT; s++) begin
          match_addr_r[s] <= '0;
        end
      end else begin
        found_r <= found_nxt;
        for (int s = 0; s < SIG_COUNT; s++) begin
          match_addr_r[s] <= match_addr_nxt[s];
        end
      end
    end
  end

  // unfound signatures keep a zero address, so the record is the result
  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= {match_addr_nxt[3], match_addr_nxt[2],
                     match_addr_nxt[1], match_addr_nxt[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

FILE: tb/code_signature_scanner_tb.sv
// self-checking testbench for code_signature_scanner: signature hits, image edges, backpressure
module code_signature_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csig_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned LONG_HOLD = 400;
  localparam logic [12:0] RX_PATTERN_BITS = 13'b1011001110110;

  typedef logic [SIG_COUNT-1:0][WORD_W-1:0] addr_set_t;
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [31:0]   cfg_wdata = '0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [31:0]   in_tdata = '0;   // code_word
  logic          in_tlast = 1'b0; // last_word
  logic          out_tvalid;
  logic          out_tready = 1'b1;
  logic [127:0]  out_tdata;       // strcmp_address, strchr_address,
                                  // byte_fill_address, word_fill_address

  code_signature_scanner i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // scanner state as the block should hold it
  word_t       scan_window [WIN_DEPTH];
  int unsigned scan_count;
  addr_set_t   scan_addr;
  sig_vec_t    scan_found;
  word_t       base_address;
  addr_set_t   pending_addrs [$];

  string field_names [SIG_COUNT] =
    '{"strcmp_address", "strchr_address", "byte_fill_address", "word_fill_address"};

  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned words_sent = 0;
  int unsigned images_sent = 0;
  int unsigned results_checked = 0;
  int unsigned addr_settings = 0;
  int unsigned hits_seen [SIG_COUNT] = '{0, 0, 0, 0};

  // sender and receiver idling controls
  int unsigned gap_max = 0;
  int unsigned burst_left = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned rx_phase = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  function automatic void clear_scan();
    for (int i = 0; i < WIN_DEPTH; i++) scan_window[i] = '0;
    scan_count = 0;
    scan_addr = '0;
    scan_found = '0;
  endfunction

  // match the new word plus window against every signature still open, then shift it in
  function automatic void absorb_word(word_t w, logic last);
    word_t       recent [SIG_MAXLEN];
    bit          hit;
    int unsigned start;
    if (scan_count < MAX_WORDS) begin
      recent[0] = w;
      for (int i = 0; i < WIN_DEPTH; i++) recent[i + 1] = scan_window[i];
      for (int s = 0; s < SIG_COUNT; s++) begin
        if (!scan_found[s] && scan_count + 1 >= SIG_LEN[s]) begin
          hit = 1'b1;
          for (int k = 0; k < SIG_LEN[s] && hit; k++)
            if (recent[SIG_LEN[s] - 1 - k] != SIG_WORDS[s][k]) hit = 1'b0;
          if (hit) begin
            start = scan_count + 1 - SIG_LEN[s];
            scan_found[s] = 1'b1;
            // a hit at byte offset zero is reported as not found
            scan_addr[s] = (start == 0) ? '0 : base_address + word_t'(start * 4);
          end
        end
      end
      for (int i = WIN_DEPTH - 1; i > 0; i--) scan_window[i] = scan_window[i - 1];
      scan_window[0] = w;
      scan_count++;
    end
    if (last) begin
      pending_addrs.push_back(scan_addr);
      clear_scan();
    end
  endfunction

  always @(posedge clk) begin : check_results
    addr_set_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_addrs.size() == 0) begin
        $error("result with no image pending: %h", out_tdata);
        fail_cnt++;
      end else begin
        want = pending_addrs.pop_front();
        for (int s = 0; s < SIG_COUNT; s++) begin
          if (out_tdata[32*s +: 32] !== want[s]) begin
            $error("%s: expected %h, got %h", field_names[s], want[s], out_tdata[32*s +: 32]);
            fail_cnt++;
          end
          if (want[s] != '0) hits_seen[s]++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("code_signature_scanner: mismatch");
      $finish;
    end
  end

  // receiver: long hold-offs on request, otherwise its own stall pattern
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_tready <= RX_PATTERN_BITS[rx_phase];
          rx_phase = (rx_phase + 1) % 13;
        end
      endcase
    end
  end

  task automatic send_word(input word_t w, input logic last);
    int unsigned gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_word(w, last);
    words_sent++;
    if (last) images_sent++;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, gap_max);
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_load_address(input word_t addr);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= addr;
    @(negedge clk);
    cfg_we <= 1'b0;
    base_address = addr;
    addr_settings++;
  endtask

  task automatic send_signature(input int unsigned s, input int unsigned first,
                                input int unsigned count, input logic last_on_end);
    for (int k = first; k < first + count; k++)
      send_word(SIG_WORDS[s][k], last_on_end && (k == first + count - 1));
  endtask

  task automatic test_field_extremes();
    set_load_address('1);
    send_word('1, 1'b1);
    send_word('0, 1'b1);
  endtask

  task automatic test_directed_signatures();
    set_load_address(32'h1000_0000);
    // byte fill at the image start reads as not found; its repeat is ignored
    send_signature(2, 0, SIG_LEN[2], 1'b0);
    send_signature(2, 0, SIG_LEN[2], 1'b1);
    // string compare one word in, address wraps past the top
    set_load_address(32'hFFFF_FFFE);
    send_word(32'h0000_0000, 1'b0);
    send_signature(0, 0, SIG_LEN[0], 1'b1);
    // a signature split over two images must not match
    send_signature(1, 0, 4, 1'b1);
    send_signature(1, 4, 4, 1'b1);
  endtask

  task automatic send_random_image(input int unsigned target);
    word_t       body [$];
    int unsigned pick, s, n, bad;
    while (body.size() < target) begin
      pick = $urandom_range(0, 15);
      s = $urandom_range(0, SIG_COUNT - 1);
      if (pick < 5) begin
        for (int k = 0; k < SIG_LEN[s]; k++) body.push_back(SIG_WORDS[s][k]);
      end else if (pick < 7) begin
        n = $urandom_range(1, SIG_LEN[s] - 1);
        for (int k = 0; k < n; k++) body.push_back(SIG_WORDS[s][k]);
      end else if (pick < 9) begin
        // whole signature with one bit flipped somewhere
        bad = $urandom_range(0, SIG_LEN[s] - 1);
        for (int k = 0; k < SIG_LEN[s]; k++)
          body.push_back(k == bad ? SIG_WORDS[s][k] ^ (word_t'(1) << $urandom_range(0, 31))
                                  : SIG_WORDS[s][k]);
      end else if (pick < 11) begin
        body.push_back(SIG_WORDS[s][$urandom_range(0, SIG_LEN[s] - 1)]);
      end else begin
        body.push_back($urandom());
      end
    end
    for (int i = 0; i < body.size(); i++) send_word(body[i], i == body.size() - 1);
  endtask

  task automatic test_random_images();
    word_t       addr_list [6] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0,
                                   32'h0, 32'hFFFF_FFC0};
    int unsigned gap_list [3] = '{0, 3, 8};
    int unsigned phase_end;
    addr_list[3] = $urandom();
    addr_list[4] = $urandom();
    for (int p = 0; p < 6; p++) begin
      set_load_address(addr_list[p]);
      gap_max = gap_list[p % 3];
      rx_mode = rx_mode_e'(p % 3);
      phase_end = words_sent + RANDOM_ITEMS / 6;
      while (words_sent < phase_end)
        send_random_image($urandom_range(0, 7) == 0 ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 30));
    end
  endtask

  // receiver holds off while short images keep coming, so the input backs up
  task automatic test_backpressure();
    drain_results();
    gap_max = 0;
    rx_mode = RX_RANDOM;
    @(posedge clk);
    hold_request = LONG_HOLD;
    for (int i = 0; i < 12; i++) send_random_image(3);
    rx_mode = RX_ALWAYS;
  endtask

  initial begin
    clear_scan();
    base_address = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_directed_signatures();
    test_backpressure();
    test_random_images();
    drain_results();
    repeat (8) @(posedge clk);
    $display("ran %0d words in %0d images over %0d load addresses, %0d results checked",
             words_sent, images_sent, addr_settings, results_checked);
    $display("nonzero addresses seen: strcmp %0d, strchr %0d, byte fill %0d, word fill %0d",
             hits_seen[0], hits_seen[1], hits_seen[2], hits_seen[3]);
    if (fail_cnt == 0) begin
      $display("code_signature_scanner: match");
    end else begin
      $display("code_signature_scanner: mismatch");
    end
    $finish;
  end

endmodule
